[hw/rtl/ilp_pkg.sv]
// Shared types and constants for the integer literal parser.
package ilp_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } ilp_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [4:0]         radix;
    logic [1:0]         size_code;
    logic               is_signed;
  } ilp_out_t;

  typedef struct packed {
    logic [1:0]  char_position;
    logic        first_is_zero;
    logic [4:0]  radix;
    logic [63:0] accumulator;
    logic        stopped;
    logic        saw_unsigned;
    logic [39:0] tail_chars;
  } ilp_state_t;

  localparam logic [4:0] RADIX_BIN = 5'd2;
  localparam logic [4:0] RADIX_TER = 5'd3;
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_HEX = 5'd16;
  localparam logic [4:0] RADIX_NONE = 5'd0;

  localparam logic [1:0] SIZE_INT8  = 2'd0;
  localparam logic [1:0] SIZE_INT16 = 2'd1;
  localparam logic [1:0] SIZE_INT32 = 2'd2;
  localparam logic [1:0] SIZE_INT64 = 2'd3;

  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] CHAR_UC_A     = 8'h41;
  localparam logic [7:0] CHAR_UC_Z     = 8'h5A;
  localparam logic [7:0] CHAR_LC_A     = 8'h61;
  localparam logic [7:0] CHAR_LC_Z     = 8'h7A;
  localparam logic [7:0] CHAR_BACKTICK = 8'h60;
  localparam logic [7:0] CHAR_U        = 8'h75;

  localparam logic [31:0] SUF_INT8  = 32'h696E7438;
  localparam logic [39:0] SUF_INT16 = 40'h696E743136;
  localparam logic [39:0] SUF_INT32 = 40'h696E743332;
  localparam logic [39:0] SUF_INT64 = 40'h696E743634;

  localparam ilp_state_t ILP_STATE_RST = '{
    char_position: 2'd0,
    first_is_zero: 1'b0,
    radix:         RADIX_DEC,
    accumulator:   64'd0,
    stopped:       1'b0,
    saw_unsigned:  1'b0,
    tail_chars:    40'd0
  };

endpackage

[hw/rtl/ilp_step.sv]
// One character of parsing: next parser state and the result for a final character.
module ilp_step import ilp_pkg::*; (
  input  ilp_state_t state,
  input  ilp_in_t    item,
  output ilp_state_t state_nxt,
  output ilp_out_t   result
);

  logic [7:0]  ch;
  logic [4:0]  pfx_radix;
  logic        stop_char;
  logic [5:0]  digit;
  logic [63:0] scaled;
  logic [39:0] tail;
  ilp_state_t  upd;

  assign ch = item.character;

  always_comb begin
    case (ch)
      "b", "B":           pfx_radix = RADIX_BIN;
      "t", "T":           pfx_radix = RADIX_TER;
      "o", "O", "c", "C": pfx_radix = RADIX_OCT;
      "d", "D":           pfx_radix = RADIX_DEC;
      "h", "H", "x", "X": pfx_radix = RADIX_HEX;
      default:            pfx_radix = RADIX_NONE;
    endcase
  end

  assign stop_char = (ch == "s") || (ch == "u") || (ch == "i") || (ch == "n") || (ch == "t");

  always_comb begin
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      digit = 6'(ch - CHAR_ZERO);
    end else if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
      digit = 6'(ch - CHAR_LC_A + 8'd10);
    end else if (ch >= CHAR_UC_A && ch <= CHAR_UC_Z) begin
      digit = 6'(ch - CHAR_UC_A + 8'd10);
    end else begin
      digit = 6'd0;
    end
  end

  // Radix is one of a few constants: scale by shifts and at most one add.
  always_comb begin
    case (state.radix)
      RADIX_BIN: scaled = state.accumulator << 1;
      RADIX_TER: scaled = (state.accumulator << 1) + state.accumulator;
      RADIX_OCT: scaled = state.accumulator << 3;
      RADIX_HEX: scaled = state.accumulator << 4;
      default:   scaled = (state.accumulator << 3) + (state.accumulator << 1);
    endcase
  end

  assign tail = {state.tail_chars[31:0], ch};

  always_comb begin
    upd = state;
    upd.tail_chars = tail;
    if (ch == CHAR_U) begin
      upd.saw_unsigned = 1'b1;
    end
    if (state.char_position == 2'd1 && state.first_is_zero && pfx_radix != RADIX_NONE) begin
      upd.radix       = pfx_radix;
      upd.accumulator = 64'd0;
    end else if (!state.stopped && ch != CHAR_BACKTICK) begin
      if (stop_char) begin
        upd.stopped = 1'b1;
      end else begin
        upd.accumulator = scaled + {58'd0, digit};
      end
    end
    if (state.char_position == 2'd0) begin
      upd.first_is_zero = (ch == CHAR_ZERO);
    end
    if (state.char_position != 2'd2) begin
      upd.char_position = state.char_position + 2'd1;
    end
  end

  always_comb begin
    result.value     = upd.accumulator;
    result.radix     = upd.radix;
    result.is_signed = !upd.saw_unsigned;
    if (tail[31:0] == SUF_INT8) begin
      result.size_code = SIZE_INT8;
    end else if (tail == SUF_INT16) begin
      result.size_code = SIZE_INT16;
    end else if (tail == SUF_INT32) begin
      result.size_code = SIZE_INT32;
    end else if (tail == SUF_INT64) begin
      result.size_code = SIZE_INT64;
    end else begin
      result.size_code = SIZE_INT32;
    end
  end

  // Return to the reset state once the literal ends.
  assign state_nxt = item.is_last ? ILP_STATE_RST : upd;

endmodule

[hw/rtl/integer_literal_parser_unit.sv]
// Top level of the integer literal parser: input register, parse step, result register.
// The parse step is combinational, between the input and result registers.
// Throughput: one character per cycle unless a final one waits on an unread result.
// A final character waits in the input register only while an earlier result is unread.
// Reset (synchronous, rst_n low): clears both register valids and the parser state.
module integer_literal_parser_unit import ilp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ilp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ilp_out_t out_data
);

  // Input register: one character awaiting its parse step.
  ilp_in_t    hold_r;
  logic       hold_vld_r;
  logic       hold_vld_nxt;

  // Parser state carried between characters of one literal.
  ilp_state_t state_r;
  ilp_state_t state_nxt;

  // Result register.
  ilp_out_t   out_r;
  logic       out_vld_r;
  logic       out_vld_nxt;

  ilp_out_t   step_res;
  logic       advance;
  logic       in_xfer;

  ilp_step u_step (
    .state     (state_r),
    .item      (hold_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // Advance the held character unless it would overwrite an unread result.
  // Non-final characters never touch the result register, so they always move.
  assign advance  = hold_vld_r && (!hold_r.is_last || !out_vld_r || out_ready);
  assign in_ready = !hold_vld_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    hold_vld_nxt = in_xfer ? 1'b1 : (advance ? 1'b0 : hold_vld_r);
    if (advance && hold_r.is_last) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      state_r    <= ILP_STATE_RST;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hold_r <= in_data;
    end
    if (advance && hold_r.is_last) begin
      out_r <= step_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/ilp_checker.sv]
// Port-level assertions for the integer literal parser, bound to the top level.
module ilp_checker import ilp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input ilp_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input ilp_out_t out_data
);

  // Hold an unread result steady.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_radix_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.radix == RADIX_BIN || out_data.radix == RADIX_TER ||
                   out_data.radix == RADIX_OCT || out_data.radix == RADIX_DEC ||
                   out_data.radix == RADIX_HEX))
    else $error("illegal radix in result");

  // Input stalls only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the channels");

endmodule

bind integer_literal_parser_unit ilp_checker u_ilp_checker (.*);
